// ----- rtl/core/skp_pkg.sv -----
// ----------------------------------------------------------------------------
// skp_pkg
// Shared types and constants for the serial keypad scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package skp_pkg;

    localparam int KEY_COUNT_DEFAULT = 16;

    localparam int CNT_W   = 12;
    localparam int KEY_W   = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [CNT_W-1:0] PREWAIT_RESET  = 12'd50;
    localparam logic [CNT_W-1:0] POSTWAIT_RESET = 12'd1000;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_PREWAIT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_POSTWAIT = 1'b1;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_PRE  = 4'b0010,
        PH_READ = 4'b0100,
        PH_POST = 4'b1000
    } skp_phase_t;

    typedef struct packed {
        logic [CNT_W-1:0] prewait_ticks;
        logic [CNT_W-1:0] postwait_ticks;
    } skp_cfg_t;

    typedef struct packed {
        logic             clock_level;
        logic             key_ready;
        logic [KEY_W-1:0] key_code;
        logic             busy_res;
    } skp_result_t;

endpackage

`default_nettype wire

// ----- rtl/core/serial_keypad_scanner_top.sv -----
// ----------------------------------------------------------------------------
// serial_keypad_scanner_top
// Scanner for a two-wire serial touch keypad, one channel.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one beat per timer tick (action = 0)
// or data-ready trigger (action = 1), with the sampled data_level.
// Output channel (out_valid / out_stall): exactly one result beat per input
// beat, in order: clock line level, key_ready pulse, key_code, busy_res.
// Configuration (cfg_valid / cfg_ready): index 0 = prewait_ticks,
// index 1 = postwait_ticks; cfg_ready is always high. Write only when idle.
// Throughput: one beat per cycle while in_stall is low; the whole state
// update is one compare and increment on the 12-bit tick counter. The result
// of a taken beat is registered in the result buffer, behind older results.
// A two-entry result buffer lets input beats flow while one result waits;
// in_stall rises only when both entries hold undelivered results.
// Reset: scanner idle, clock line high, counters and key cleared, waits back
// to 50 and 1000 ticks, result buffer empty.
// A second keypad channel is a second instance of this block.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_keypad_scanner_top #(
    parameter int KEY_COUNT = skp_pkg::KEY_COUNT_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          action,
    input  wire logic                          data_level,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               clock_level,
    output logic                               key_ready,
    output logic [skp_pkg::KEY_W-1:0]          key_code,
    output logic                               busy_res,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [skp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [skp_pkg::CNT_W-1:0]     cfg_data
);

    skp_pkg::skp_cfg_t    cfg_reg, cfg_next;
    skp_pkg::skp_result_t core_result;
    skp_pkg::skp_result_t q_data;
    logic                 q_full;
    logic                 accept;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;
    assign accept    = in_valid && !q_full;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                skp_pkg::CFG_PREWAIT:  cfg_next.prewait_ticks  = cfg_data;
                skp_pkg::CFG_POSTWAIT: cfg_next.postwait_ticks = cfg_data;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prewait_ticks  <= skp_pkg::PREWAIT_RESET;
            cfg_reg.postwait_ticks <= skp_pkg::POSTWAIT_RESET;
        end
        else
            cfg_reg <= cfg_next;
    end

    skp_scan_core #(
        .KEY_COUNT (KEY_COUNT)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .action     (action),
        .data_level (data_level),
        .cfg        (cfg_reg),
        .result     (core_result)
    );

    skp_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (core_result),
        .full      (q_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (q_data)
    );

    assign clock_level = q_data.clock_level;
    assign key_ready   = q_data.key_ready;
    assign key_code    = q_data.key_code;
    assign busy_res    = q_data.busy_res;

endmodule

`default_nettype wire

// ----- rtl/core/skp_scan_core.sv -----
// ----------------------------------------------------------------------------
// skp_scan_core
// Scan sequencer: pre-wait, clocked read of the key bits, post-wait, publish.
// ----------------------------------------------------------------------------
`default_nettype none

module skp_scan_core #(
    parameter int KEY_COUNT = skp_pkg::KEY_COUNT_DEFAULT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 accept,
    input  wire logic                 action,
    input  wire logic                 data_level,
    input  wire skp_pkg::skp_cfg_t    cfg,
    output skp_pkg::skp_result_t      result
);

    localparam int CW = skp_pkg::CNT_W;
    localparam int KW = skp_pkg::KEY_W;
    localparam logic [CW-1:0] READ_TICKS = CW'(2 * KEY_COUNT);

    skp_pkg::skp_phase_t phase_reg, phase_next;
    logic [CW-1:0]       tick_count_reg, tick_count_next;
    logic [KW-1:0]       pending_key_reg, pending_key_next;
    logic                clock_out_reg, clock_out_next;
    logic                ready;
    logic [KW-1:0]       code;
    logic [CW-1:0]       tick_inc;
    logic [CW-2:0]       key_num;

    assign tick_inc = tick_count_reg + CW'(1);
    assign key_num  = tick_count_reg[CW-1:1] + (CW-1)'(1);

    always_comb
    begin
        phase_next       = phase_reg;
        tick_count_next  = tick_count_reg;
        pending_key_next = pending_key_reg;
        clock_out_next   = clock_out_reg;
        ready            = 1'b0;
        code             = '0;
        if (action)
        begin
            phase_next      = skp_pkg::PH_PRE;
            tick_count_next = '0;
        end
        else
        begin
            unique case (phase_reg)
                skp_pkg::PH_IDLE:
                begin
                end
                skp_pkg::PH_PRE:
                begin
                    if (tick_count_reg < cfg.prewait_ticks)
                        tick_count_next = tick_inc;
                    else
                    begin
                        phase_next      = skp_pkg::PH_READ;
                        tick_count_next = '0;
                    end
                end
                skp_pkg::PH_READ:
                begin
                    if (tick_count_reg < READ_TICKS)
                    begin
                        if (!tick_count_reg[0])
                            clock_out_next = 1'b0;
                        else
                        begin
                            // active-low sample, last low key wins
                            if (!data_level)
                                pending_key_next = key_num[KW-1:0];
                            clock_out_next = 1'b1;
                        end
                        tick_count_next = tick_inc;
                    end
                    else
                    begin
                        phase_next      = skp_pkg::PH_POST;
                        tick_count_next = '0;
                    end
                end
                skp_pkg::PH_POST:
                begin
                    if (tick_count_reg < cfg.postwait_ticks)
                        tick_count_next = tick_inc;
                    else
                    begin
                        phase_next       = skp_pkg::PH_IDLE;
                        tick_count_next  = '0;
                        ready            = 1'b1;
                        code             = pending_key_reg;
                        pending_key_next = '0;
                    end
                end
                default:
                begin
                    phase_next = skp_pkg::PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= skp_pkg::PH_IDLE;
            tick_count_reg  <= '0;
            pending_key_reg <= '0;
            clock_out_reg   <= 1'b1;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            tick_count_reg  <= tick_count_next;
            pending_key_reg <= pending_key_next;
            clock_out_reg   <= clock_out_next;
        end
    end

    always_comb
    begin
        result.clock_level = clock_out_next;
        result.key_ready   = ready;
        result.key_code    = code;
        result.busy_res    = (phase_next != skp_pkg::PH_IDLE);
    end

endmodule

`default_nettype wire

// ----- rtl/core/skp_out_queue.sv -----
// ----------------------------------------------------------------------------
// skp_out_queue
// Two-entry result buffer; keeps the input side moving while a beat waits.
// ----------------------------------------------------------------------------
`default_nettype none

module skp_out_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire skp_pkg::skp_result_t push_data,
    output logic                      full,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output skp_pkg::skp_result_t      out_data
);

    skp_pkg::skp_result_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign out_valid = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign pop       = out_valid && !out_stall;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire
